// File: src/adpt1_pkg.sv
// Shared constants, codes and control types of the adaptive double PT1 filter.
package adpt1_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int STATE_BITS     = 32;
    localparam int STATE_FRAC     = STATE_BITS - SAMPLE_BITS;
    localparam int GAIN_BITS      = 24;
    localparam int GAIN_FRAC      = 16;
    localparam int ADAPT_SHIFT    = STATE_FRAC + GAIN_FRAC - COEF_FRAC_BITS;

    // shared multiplier: signed difference times zero-extended coefficient or gain
    localparam int DIFF_BITS = STATE_BITS + 2;
    localparam int PROD_BITS = DIFF_BITS + GAIN_BITS + 1;
    localparam int ACC_BITS  = PROD_BITS - COEF_FRAC_BITS + 1;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] REG_K_DERIV       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_K_MIN         = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_K_MAX         = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ADAPT_GAIN    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_STEP      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLEW_ENABLE   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_VALUE = 3'd6;

    localparam logic [COEF_BITS-1:0]   RST_K_DERIV    = 16'd6554;
    localparam logic [COEF_BITS-1:0]   RST_K_MIN      = 16'd655;
    localparam logic [COEF_BITS-1:0]   RST_K_MAX      = 16'd32768;
    localparam logic [GAIN_BITS-1:0]   RST_ADAPT_GAIN = 24'd65536;
    localparam logic [SAMPLE_BITS-1:0] RST_MAX_STEP   = 16'd0;
    localparam logic                   RST_SLEW       = 1'b0;
    localparam logic [SAMPLE_BITS-1:0] RST_INITIAL    = 16'd0;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LIMIT,
        OP_MUL_D1,
        OP_UPD_D1,
        OP_MUL_D2,
        OP_UPD_D2,
        OP_MUL_K,
        OP_UPD_K,
        OP_MUL_O1,
        OP_UPD_O1,
        OP_MUL_O2,
        OP_UPD_O2
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } cmd_t;

endpackage

// File: src/adpt1_sample_if.sv
// Input channel: one raw sample per transfer.
interface adpt1_sample_if;
    import adpt1_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// File: src/adpt1_filtered_if.sv
// Output channel: one smoothed Q16.16 sample per transfer.
interface adpt1_filtered_if;
    import adpt1_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [STATE_BITS-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink (input valid, input filtered, output ready);
endinterface

// File: src/adpt1_ctrl.sv
// Sequencer: steps one sample through limit, two smoothers, gain and output filter.
module adpt1_ctrl
    import adpt1_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIMIT,
        S_MUL_D1,
        S_UPD_D1,
        S_MUL_D2,
        S_UPD_D2,
        S_MUL_K,
        S_UPD_K,
        S_MUL_O1,
        S_UPD_O1,
        S_MUL_O2,
        S_UPD_O2
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // result register is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:
            begin
                cmd.op     = OP_LIMIT;
                state_next = S_MUL_D1;
            end
            S_MUL_D1:
            begin
                cmd.op     = OP_MUL_D1;
                state_next = S_UPD_D1;
            end
            S_UPD_D1:
            begin
                cmd.op     = OP_UPD_D1;
                state_next = S_MUL_D2;
            end
            S_MUL_D2:
            begin
                cmd.op     = OP_MUL_D2;
                state_next = S_UPD_D2;
            end
            S_UPD_D2:
            begin
                cmd.op     = OP_UPD_D2;
                state_next = S_MUL_K;
            end
            S_MUL_K:
            begin
                cmd.op     = OP_MUL_K;
                state_next = S_UPD_K;
            end
            S_UPD_K:
            begin
                cmd.op     = OP_UPD_K;
                state_next = S_MUL_O1;
            end
            S_MUL_O1:
            begin
                cmd.op     = OP_MUL_O1;
                state_next = S_UPD_O1;
            end
            S_UPD_O1:
            begin
                cmd.op     = OP_UPD_O1;
                state_next = S_MUL_O2;
            end
            S_MUL_O2:
            begin
                cmd.op     = OP_MUL_O2;
                state_next = S_UPD_O2;
            end
            S_UPD_O2:
            begin
                // the last stage doubles as the result register, so hold it until free
                if (slot_free)
                begin
                    cmd.op     = OP_UPD_O2;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = (out_valid_reg && !out_ready) || (cmd.op == OP_UPD_O2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: src/adpt1_dpath.sv
// Datapath: config registers, filter state, shared multiplier and update logic.
module adpt1_dpath
    import adpt1_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    output logic signed [STATE_BITS-1:0]  filtered
);

    localparam logic signed [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
    localparam logic signed [PROD_BITS-1:0]  ROUND_HALF =
        {{(PROD_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

    // configuration
    logic [COEF_BITS-1:0]   k_deriv_reg;
    logic [COEF_BITS-1:0]   k_min_reg;
    logic [COEF_BITS-1:0]   k_max_reg;
    logic [GAIN_BITS-1:0]   adapt_gain_reg;
    logic [SAMPLE_BITS-1:0] max_step_reg;
    logic                   slew_enable_reg;

    // filter state
    logic signed [SAMPLE_BITS-1:0] prev_raw_reg;
    logic signed [STATE_BITS-1:0]  d1_reg;
    logic signed [STATE_BITS-1:0]  d2_reg;
    logic signed [STATE_BITS-1:0]  ps_reg;
    logic signed [STATE_BITS-1:0]  o1_reg;
    logic signed [STATE_BITS-1:0]  o2_reg;

    // working registers
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [STATE_BITS-1:0]  xq_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic [COEF_BITS-1:0]          kout_reg;

    // slew limit
    logic signed [SAMPLE_BITS:0]   step;
    logic signed [SAMPLE_BITS:0]   step_max;
    logic signed [SAMPLE_BITS:0]   step_min;
    logic [SAMPLE_BITS-1:0]        lim;
    logic signed [STATE_BITS-1:0]  xq_next;

    // multiplier
    logic signed [STATE_BITS-1:0]  sub_p;
    logic signed [STATE_BITS-1:0]  sub_q;
    logic [GAIN_BITS-1:0]          mul_b;
    logic signed [DIFF_BITS-1:0]   mul_a;
    logic signed [PROD_BITS-1:0]   product;

    // PT1 update
    logic signed [STATE_BITS-1:0]  upd_c;
    logic signed [PROD_BITS-1:0]   rsum;
    logic signed [ACC_BITS-1:0]    acc;
    logic [ACC_BITS-STATE_BITS:0]  acc_hi;
    logic signed [STATE_BITS-1:0]  upd_val;

    // adaptive coefficient
    logic [PROD_BITS-1:0]             mag_prod;
    logic [PROD_BITS-ADAPT_SHIFT-1:0] add_val;
    logic                             add_big;
    logic [COEF_BITS:0]               ksum;
    logic [COEF_BITS-1:0]             k_next;

    always_comb
    begin
        step     = {x_reg[SAMPLE_BITS-1], x_reg} - {prev_raw_reg[SAMPLE_BITS-1], prev_raw_reg};
        step_max = $signed({1'b0, max_step_reg});
        step_min = -step_max;
        lim      = x_reg;
        if (slew_enable_reg)
        begin
            // limited value lies between prev_raw and x, so the wrap is harmless
            if (step > step_max)
            begin
                lim = prev_raw_reg + max_step_reg;
            end
            else if (step < step_min)
            begin
                lim = prev_raw_reg - max_step_reg;
            end
        end
        xq_next = $signed({lim, {STATE_FRAC{1'b0}}});
    end

    always_comb
    begin
        sub_p = xq_reg;
        sub_q = d1_reg;
        mul_b = {{(GAIN_BITS-COEF_BITS){1'b0}}, k_deriv_reg};
        case (cmd.op)
            OP_MUL_D2:
            begin
                sub_p = d1_reg;
                sub_q = d2_reg;
            end
            OP_MUL_K:
            begin
                sub_p = d2_reg;
                sub_q = ps_reg;
                mul_b = adapt_gain_reg;
            end
            OP_MUL_O1:
            begin
                sub_q = o1_reg;
                mul_b = {{(GAIN_BITS-COEF_BITS){1'b0}}, kout_reg};
            end
            OP_MUL_O2:
            begin
                sub_p = o1_reg;
                sub_q = o2_reg;
                mul_b = {{(GAIN_BITS-COEF_BITS){1'b0}}, kout_reg};
            end
            default:
            begin
            end
        endcase
        mul_a   = {{2{sub_p[STATE_BITS-1]}}, sub_p} - {{2{sub_q[STATE_BITS-1]}}, sub_q};
        product = mul_a * $signed({1'b0, mul_b});
    end

    always_comb
    begin
        case (cmd.op)
            OP_UPD_D2: upd_c = d2_reg;
            OP_UPD_O1: upd_c = o1_reg;
            OP_UPD_O2: upd_c = o2_reg;
            default:   upd_c = d1_reg;
        endcase
        rsum   = prod_reg + ROUND_HALF;
        acc    = {{(ACC_BITS-STATE_BITS){upd_c[STATE_BITS-1]}}, upd_c}
               + {rsum[PROD_BITS-1], rsum[PROD_BITS-1:COEF_FRAC_BITS]};
        acc_hi = acc[ACC_BITS-1:STATE_BITS-1];
        if ((&acc_hi) || !(|acc_hi))
        begin
            upd_val = acc[STATE_BITS-1:0];
        end
        else if (acc[ACC_BITS-1])
        begin
            upd_val = STATE_MIN;
        end
        else
        begin
            upd_val = STATE_MAX;
        end
    end

    // |diff| * gain taken as |diff * gain| since the gain is never negative
    always_comb
    begin
        mag_prod = prod_reg[PROD_BITS-1] ? PROD_BITS'(-prod_reg) : PROD_BITS'(prod_reg);
        add_val  = mag_prod[PROD_BITS-1:ADAPT_SHIFT];
        add_big  = |add_val[PROD_BITS-ADAPT_SHIFT-1:COEF_BITS];
        ksum     = {1'b0, k_min_reg} + {1'b0, add_val[COEF_BITS-1:0]};
        if (add_big || (ksum > {1'b0, k_max_reg}))
        begin
            k_next = k_max_reg;
        end
        else
        begin
            k_next = ksum[COEF_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_deriv_reg     <= RST_K_DERIV;
            k_min_reg       <= RST_K_MIN;
            k_max_reg       <= RST_K_MAX;
            adapt_gain_reg  <= RST_ADAPT_GAIN;
            max_step_reg    <= RST_MAX_STEP;
            slew_enable_reg <= RST_SLEW;
            prev_raw_reg    <= $signed(RST_INITIAL);
            d1_reg          <= '0;
            d2_reg          <= '0;
            ps_reg          <= '0;
            o1_reg          <= '0;
            o2_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_K_DERIV:       k_deriv_reg     <= cfg_data[COEF_BITS-1:0];
                    REG_K_MIN:         k_min_reg       <= cfg_data[COEF_BITS-1:0];
                    REG_K_MAX:         k_max_reg       <= cfg_data[COEF_BITS-1:0];
                    REG_ADAPT_GAIN:    adapt_gain_reg  <= cfg_data[GAIN_BITS-1:0];
                    REG_MAX_STEP:      max_step_reg    <= cfg_data[SAMPLE_BITS-1:0];
                    REG_SLEW_ENABLE:   slew_enable_reg <= cfg_data[0];
                    REG_INITIAL_VALUE: prev_raw_reg    <= $signed(cfg_data[SAMPLE_BITS-1:0]);
                    default:
                    begin
                    end
                endcase
            end
            case (cmd.op)
                OP_LIMIT:  prev_raw_reg <= x_reg;
                OP_UPD_D1: d1_reg <= upd_val;
                OP_UPD_D2:
                begin
                    d2_reg <= upd_val;
                end
                OP_UPD_K:  ps_reg <= d2_reg;
                OP_UPD_O1: o1_reg <= upd_val;
                OP_UPD_O2: o2_reg <= upd_val;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= sample;
        end
        if (cmd.op == OP_LIMIT)
        begin
            xq_reg <= xq_next;
        end
        if (cmd.op == OP_MUL_D1 || cmd.op == OP_MUL_D2 || cmd.op == OP_MUL_K ||
            cmd.op == OP_MUL_O1 || cmd.op == OP_MUL_O2)
        begin
            prod_reg <= product;
        end
        if (cmd.op == OP_UPD_K)
        begin
            kout_reg <= k_next;
        end
    end

    assign filtered = o2_reg;

endmodule

// File: src/adaptive_double_pt1_filter.sv
// Top level of the adaptive double PT1 filter: sequencer plus datapath.
//
//   channel      dir   handshake      payload
//   sample_ch    in    valid/ready    sample   s16
//   filtered_ch  out   valid/ready    filtered s32 (Q16.16)
//   cfg          in    cfg_we         cfg_index[2:0], cfg_data[23:0]
//
// Each item steps through accept, slew limit, then five multiply/update pairs
// (two smoother stages, adaptive coefficient, two output stages) using one
// shared 34x25 multiplier.
// Reset (rst_n low, asynchronous) loads the register defaults and clears all filter state.
// A new sample is taken while the previous result waits; the last output stage
// holds until the result register has been drained.
module adaptive_double_pt1_filter
    import adpt1_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    adpt1_sample_if.sink             sample_ch,
    adpt1_filtered_if.source         filtered_ch,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cmd_t cmd;

    adpt1_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (sample_ch.ready),
        .out_valid (filtered_ch.valid),
        .out_ready (filtered_ch.ready),
        .cmd       (cmd)
    );

    adpt1_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (sample_ch.sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .filtered  (filtered_ch.filtered)
    );

endmodule
